[design/cvss_pkg.sv]
package cvss_pkg;

  localparam int unsigned STEP_COUNT  = 16;
  localparam int unsigned GATE_LENGTH = 1024;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned GATE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BANK_COUNT = 4;

  localparam logic signed [SAMPLE_W-1:0] HIGH_LEVEL = 16'sd16384;
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(STEP_COUNT);
  localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(1);
  localparam logic [GATE_W-1:0] GATE_LOAD = GATE_W'(GATE_LENGTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LEN = 3'd0,
    CFG_COEF    = 3'd1,
    CFG_BANK0   = 3'd2,
    CFG_BANK1   = 3'd3,
    CFG_BANK2   = 3'd4,
    CFG_BANK3   = 3'd5
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic load;
    logic finish;
  } ctrl_cmd_t;

  // (x mod len) for x up to STEP_COUNT, len from 1 to STEP_COUNT
  function automatic logic [STEP_W-1:0] wrap_step(input logic [LEN_W-1:0] x,
                                                  input logic [LEN_W-1:0] len);
    logic [9:0] lo;
    logic [9:0] hi;
    logic [STEP_W-1:0] r;
    r = '0;
    for (int k = 0; k <= STEP_COUNT; k++) begin
      lo = 10'(k) * {5'b0, len};
      hi = lo + {5'b0, len};
      if ({5'b0, x} >= lo && {5'b0, x} < hi) begin
        r = STEP_W'({5'b0, x} - lo);
      end
    end
    return r;
  endfunction

endpackage

[design/cvss_in_if.sv]
interface cvss_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] clock_sample;
  logic signed [15:0] reset_sample;

  modport source (output valid, output clock_sample, output reset_sample, input ready);
  modport sink (input valid, input clock_sample, input reset_sample, output ready);
endinterface

[design/cvss_out_if.sv]
interface cvss_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cv_out;
  logic               gate_out;

  modport source (output valid, output cv_out, output gate_out, input ready);
  modport sink (input valid, input cv_out, input gate_out, output ready);
endinterface

[design/cvss_ctrl.sv]
module cvss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cvss_pkg::ctrl_cmd_t cmd
);
  import cvss_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        // result register must be empty or draining before it is reloaded
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[design/cvss_datapath.sv]
module cvss_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [cvss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cvss_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  cvss_pkg::ctrl_cmd_t                   cmd,
  input  logic signed [cvss_pkg::SAMPLE_W-1:0]  clock_sample,
  input  logic signed [cvss_pkg::SAMPLE_W-1:0]  reset_sample,
  output logic signed [cvss_pkg::SAMPLE_W-1:0]  cv_out,
  output logic                                  gate_out
);
  import cvss_pkg::*;

  // configuration
  logic [LEN_W-1:0]      seq_len;
  logic [COEF_W-1:0]     coef;
  logic [CFG_DATA_W-1:0] bank [BANK_COUNT];

  // sequencer state
  logic [STEP_W-1:0]          step_index;
  logic                       prev_clock_high;
  logic                       prev_reset_high;
  logic [GATE_W-1:0]          gate_remaining;
  logic signed [SAMPLE_W-1:0] smoothed_cv;

  // between load and finish
  logic signed [SAMPLE_W-1:0] target;
  logic signed [SAMPLE_W:0]   diff;
  logic                       gate_level;

  logic                       clock_high;
  logic                       reset_high;
  logic [LEN_W-1:0]           active_len;
  logic [STEP_W-1:0]          step_after_reset;
  logic [STEP_W-1:0]          step_next;
  logic [GATE_W-1:0]          gate_after_reset;
  logic [GATE_W-1:0]          gate_next;
  logic [CFG_DATA_W-1:0]      bank_word;
  logic signed [SAMPLE_W-1:0] target_next;
  logic signed [2*SAMPLE_W+1:0] product;
  logic signed [2*SAMPLE_W+1:0] rounded;

  always_comb begin
    if (seq_len == '0) begin
      active_len = LEN_MIN;
    end else if (seq_len > LEN_MAX) begin
      active_len = LEN_MAX;
    end else begin
      active_len = seq_len;
    end
  end

  assign clock_high = clock_sample > HIGH_LEVEL;
  assign reset_high = reset_sample > HIGH_LEVEL;

  always_comb begin
    // reset edge first, then clock edge
    if (reset_high && !prev_reset_high) begin
      step_after_reset = '0;
      gate_after_reset = '0;
    end else begin
      step_after_reset = step_index;
      gate_after_reset = gate_remaining;
    end
    if (clock_high && !prev_clock_high) begin
      step_next = wrap_step({1'b0, step_after_reset} + LEN_W'(1), active_len);
      gate_next = GATE_LOAD;
    end else begin
      step_next = step_after_reset;
      gate_next = gate_after_reset;
    end
    bank_word   = bank[step_next[STEP_W-1:2]];
    target_next = bank_word[{step_next[1:0], 4'b0000} +: SAMPLE_W];
  end

  // cv = target + round(c * (cv - target) / 2^16), bypass falls out when c is zero
  assign product = $signed({1'b0, coef}) * diff;
  assign rounded = product + 34'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= LEN_W'(8);
      coef    <= '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
        bank[b] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEQ_LEN: seq_len <= cfg_data[LEN_W-1:0];
        CFG_COEF:    coef    <= cfg_data[COEF_W-1:0];
        CFG_BANK0:   bank[0] <= cfg_data;
        CFG_BANK1:   bank[1] <= cfg_data;
        CFG_BANK2:   bank[2] <= cfg_data;
        CFG_BANK3:   bank[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index      <= '0;
      prev_clock_high <= 1'b0;
      prev_reset_high <= 1'b0;
      gate_remaining  <= '0;
      smoothed_cv     <= '0;
      gate_out        <= 1'b0;
    end else begin
      if (cmd.load) begin
        step_index      <= step_next;
        prev_clock_high <= clock_high;
        prev_reset_high <= reset_high;
        gate_remaining  <= (gate_next != '0) ? gate_next - GATE_W'(1) : gate_next;
      end
      if (cmd.finish) begin
        smoothed_cv <= target + rounded[SAMPLE_W+15:16];
        gate_out    <= gate_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target     <= target_next;
      diff       <= {smoothed_cv[SAMPLE_W-1], smoothed_cv} -
                    {target_next[SAMPLE_W-1], target_next};
      gate_level <= gate_next != '0;
    end
  end

  assign cv_out = smoothed_cv;

endmodule

[design/cv_step_sequencer_top.sv]
// cv step sequencer
// samples: one item per audio sample, carrying a clock input and a reset input
//   sample (signed q1.15); a level above one half is high, rising edges count.
// results: one item per sample item, carrying the smoothed cv (signed q1.15)
//   and the gate level for that sample.
// config: cfg_wr_en writes cfg_data into register cfg_index:
//   0 sequence length, 1 smoothing coefficient, 2..5 step banks of four steps.
//   other indexes are ignored. write only while no item is in flight.
// timing: an item is taken in the idle state, the smoother multiply-and-round
//   runs in the calc state and lands in the result register once that register
//   is empty or draining; a new item is taken only after the last one has moved
//   into the result register.
// stall: the result register holds its item while results.ready is low; one
//   more sample item is accepted meanwhile and then waits in the multiply step.
// reset: rst (synchronous) returns length 8, coefficient 0, all steps zero,
//   step 0, gate off, cv zero, and empties the result register.
module cv_step_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cvss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cvss_pkg::CFG_DATA_W-1:0]   cfg_data,
  cvss_in_if.sink                           samples,
  cvss_out_if.source                        results
);
  import cvss_pkg::*;

  ctrl_cmd_t cmd;

  cvss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  cvss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .clock_sample (samples.clock_sample),
    .reset_sample (samples.reset_sample),
    .cv_out       (results.cv_out),
    .gate_out     (results.gate_out)
  );

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cvss_pkg::*;

  localparam logic [LEN_W-1:0] LEN_AT_RESET = LEN_W'(8);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] clock_s;
    logic signed [SAMPLE_W-1:0] reset_s;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cv;
    logic                       gate;
  } cv_gate_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvss_in_if  samples_if ();
  cvss_out_if results_if ();

  cv_step_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  // predictor copy of the registers and the sequencer state
  logic [LEN_W-1:0]            seq_len;
  logic [COEF_W-1:0]           smooth_coef;
  logic [CFG_DATA_W-1:0]       step_banks [BANK_COUNT];
  logic [STEP_W-1:0]           step_pos;
  logic                        clock_was_high;
  logic                        reset_was_high;
  logic [GATE_W-1:0]           gate_count;
  logic signed [SAMPLE_W-1:0]  cv_level;

  sample_item_t sample_queue [$];
  cv_gate_t     expected_cv_gate [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  mismatches;
  int  quiet_cycles;
  bit  item_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one sample item through the sequencer, queues the cv and gate it yields
  function automatic void advance_sequencer(input logic signed [SAMPLE_W-1:0] clock_s,
                                            input logic signed [SAMPLE_W-1:0] reset_s);
    logic                       clock_high;
    logic                       reset_high;
    logic [LEN_W-1:0]           len;
    logic signed [SAMPLE_W-1:0] target;
    longint                     acc;
    cv_gate_t                   res;
    clock_high = clock_s > HIGH_LEVEL;
    reset_high = reset_s > HIGH_LEVEL;
    if (reset_high && !reset_was_high) begin
      step_pos   = '0;
      gate_count = '0;
    end
    reset_was_high = reset_high;
    if (clock_high && !clock_was_high) begin
      len = seq_len;
      if (len == '0) len = LEN_MIN;
      if (len > LEN_MAX) len = LEN_MAX;
      step_pos   = STEP_W'((int'(step_pos) + 1) % int'(len));
      gate_count = GATE_LOAD;
    end
    clock_was_high = clock_high;
    target = $signed(step_banks[step_pos[3:2]][{step_pos[1:0], 4'b0000} +: SAMPLE_W]);
    if (smooth_coef != '0) begin
      acc = longint'(smooth_coef) * longint'(cv_level)
          + (longint'(65536) - longint'(smooth_coef)) * longint'(target);
      cv_level = SAMPLE_W'((acc + 32768) >>> 16);
    end else begin
      cv_level = target;
    end
    res.cv   = cv_level;
    res.gate = gate_count != '0;
    expected_cv_gate.push_back(res);
    if (gate_count != '0) gate_count--;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SEQ_LEN: seq_len = val[LEN_W-1:0];
      CFG_COEF:    smooth_coef = val[COEF_W-1:0];
      CFG_BANK0:   step_banks[0] = val;
      CFG_BANK1:   step_banks[1] = val;
      CFG_BANK2:   step_banks[2] = val;
      CFG_BANK3:   step_banks[3] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] bank;
    case ($urandom_range(5))
      0: write_reg(CFG_SEQ_LEN, 0);
      1: write_reg(CFG_SEQ_LEN, CFG_DATA_W'(LEN_MIN));
      2: write_reg(CFG_SEQ_LEN, CFG_DATA_W'(LEN_MAX));
      3: write_reg(CFG_SEQ_LEN, 31);
      default: write_reg(CFG_SEQ_LEN, CFG_DATA_W'($urandom_range(0, 31)));
    endcase
    case ($urandom_range(5))
      0: write_reg(CFG_COEF, 0);
      1: write_reg(CFG_COEF, 1);
      2: write_reg(CFG_COEF, 65535);
      3: write_reg(CFG_COEF, 32768);
      default: write_reg(CFG_COEF, CFG_DATA_W'($urandom_range(0, 65535)));
    endcase
    for (int b = 0; b < BANK_COUNT; b++) begin
      case ($urandom_range(5))
        0: bank = {4{SAMPLE_MIN}};
        1: bank = {4{SAMPLE_MAX}};
        default: bank = {$urandom, $urandom};
      endcase
      write_reg(CFG_IDX_W'(CFG_BANK0) + CFG_IDX_W'(b), bank);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] high_sample();
    if ($urandom_range(7) == 0) return HIGH_LEVEL + 16'sd1;
    return SAMPLE_W'($urandom_range(16385, 32767));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] low_sample();
    if ($urandom_range(7) == 0) return HIGH_LEVEL;
    return SAMPLE_W'(int'($urandom_range(0, 49152)) - 32768);
  endfunction

  task automatic queue_item(input logic signed [SAMPLE_W-1:0] clock_s,
                            input logic signed [SAMPLE_W-1:0] reset_s);
    sample_item_t it;
    it.clock_s = clock_s;
    it.reset_s = reset_s;
    sample_queue.push_back(it);
  endtask

  // square-wave clock with random run lengths, rare reset pulses, some noise
  task automatic queue_random(input int count);
    int  run_left;
    bit  level;
    logic signed [SAMPLE_W-1:0] clock_s;
    logic signed [SAMPLE_W-1:0] reset_s;
    run_left = 0;
    level = 1'b0;
    repeat (count) begin
      if (run_left == 0) begin
        level = !level;
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      clock_s = level ? high_sample() : low_sample();
      reset_s = ($urandom_range(99) < 4) ? high_sample() : low_sample();
      if ($urandom_range(99) < 8) begin
        clock_s = SAMPLE_W'($urandom);
        reset_s = SAMPLE_W'($urandom);
      end
      queue_item(clock_s, reset_s);
    end
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || samples_if.valid || expected_cv_gate.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin : drive_samples
    sample_item_t next_item;
    results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!samples_if.valid || item_taken) begin
      item_taken = 1'b0;
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = sample_queue.pop_front();
        samples_if.valid        <= 1'b1;
        samples_if.clock_sample <= next_item.clock_s;
        samples_if.reset_sample <= next_item.reset_s;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && samples_if.valid && samples_if.ready) begin
      item_taken = 1'b1;
      advance_sequencer(samples_if.clock_sample, samples_if.reset_sample);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    cv_gate_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_cv_gate.size() == 0) begin
        report_mismatch($sformatf("unexpected item cv=%0d gate=%0b",
                                  results_if.cv_out, results_if.gate_out));
      end else begin
        want = expected_cv_gate.pop_front();
        if (results_if.cv_out !== want.cv)
          report_mismatch($sformatf("cv_out %0d, want %0d", results_if.cv_out, want.cv));
        if (results_if.gate_out !== want.gate)
          report_mismatch($sformatf("gate_out %0b, want %0b", results_if.gate_out, want.gate));
      end
    end
  end

  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles with no item moving", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.clock_sample = '0;
    samples_if.reset_sample = '0;
    results_if.ready = 1'b0;
    seq_len = LEN_AT_RESET;
    smooth_coef = '0;
    for (int b = 0; b < BANK_COUNT; b++) step_banks[b] = '0;
    step_pos = '0;
    clock_was_high = 1'b0;
    reset_was_high = 1'b0;
    gate_count = '0;
    cv_level = '0;
    mismatches = 0;
    quiet_cycles = 0;
    item_taken = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 87;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // four steps, value extremes in bank 0, writes to unused indexes ignored
    write_reg(CFG_SEQ_LEN, 4);
    write_reg(CFG_COEF, 0);
    write_reg(CFG_BANK0, {SAMPLE_MAX, SAMPLE_MIN, 16'h1234, 16'hffff});
    write_reg(CFG_BANK1, 64'h0100_0200_0300_0400);
    write_reg(CFG_BANK2, 64'hc000_4000_e000_2000);
    write_reg(CFG_BANK3, 64'h7ffe_8001_0001_fffe);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, 64'h0000_0000_0000_0001);
    queue_item(0, 0);
    queue_item(HIGH_LEVEL + 16'sd1, 0);
    queue_item(SAMPLE_MAX, 0);
    queue_item(HIGH_LEVEL, 0);
    queue_item(SAMPLE_MAX, -1);
    queue_item(SAMPLE_MIN, 0);
    queue_item(20000, 0);
    queue_item(0, 0);
    queue_item(HIGH_LEVEL + 16'sd1, 0);
    queue_item(0, SAMPLE_MAX);
    queue_item(0, HIGH_LEVEL);
    // clock and reset rise together
    queue_item(SAMPLE_MAX, SAMPLE_MAX);
    queue_item(-1, SAMPLE_MIN);
    wait_drained();

    // zero length holds step zero
    write_reg(CFG_SEQ_LEN, 0);
    write_reg(CFG_COEF, 1);
    queue_item(SAMPLE_MAX, 0);
    queue_item(0, 0);
    queue_item(SAMPLE_MAX, 0);
    wait_drained();

    // oversized length, then a shortened one with the step left beyond it
    write_reg(CFG_SEQ_LEN, 31);
    write_reg(CFG_COEF, 65535);
    repeat (3) begin
      queue_item(0, 0);
      queue_item(SAMPLE_MAX, 0);
    end
    wait_drained();
    write_reg(CFG_SEQ_LEN, 2);
    queue_item(0, 0);
    queue_item(SAMPLE_MAX, 0);
    wait_drained();

    randomize_config();
    queue_random(150);
    // sender holds off until every result is back
    wait_drained();
    queue_random(150);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 11;
    randomize_config();
    queue_random(150);
    wait_drained();
    randomize_config();
    queue_random(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    randomize_config();
    queue_random(220);
    // one clock edge, then a few quiet samples while the gate stays open
    queue_item(0, 0);
    queue_item(SAMPLE_MAX, 0);
    repeat (4) queue_item(low_sample(), low_sample());
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/cvss_pkg.sv
design/cvss_in_if.sv
design/cvss_out_if.sv
design/cvss_ctrl.sv
design/cvss_datapath.sv
design/cv_step_sequencer_top.sv
tb/testbench.sv
